// File: src/ffpa_pkg.sv
// Shared types, constants and codes for the first-fit partition allocator.
package ffpa_pkg;

	localparam int NUM_PARTITIONS = 32;
	localparam int NUM_JOB_SLOTS  = 32;

	localparam int KB_W      = 10;
	localparam int LIFE_W    = 4;
	localparam int PART_W    = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
	localparam int SLOT_W    = (NUM_JOB_SLOTS > 1) ? $clog2(NUM_JOB_SLOTS) : 1;
	localparam int SCAN_N    = (NUM_PARTITIONS > NUM_JOB_SLOTS) ? NUM_PARTITIONS : NUM_JOB_SLOTS;
	localparam int CNT_W     = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
	localparam int FREED_W   = $clog2(NUM_JOB_SLOTS + 1);

	localparam logic [KB_W-1:0] KB_MAX          = 10'd1023;
	localparam logic [KB_W-1:0] LEFTOVER_RESET  = 10'd10;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_ALLOC = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic [2:0] ST_LOADED = 3'd0;
	localparam logic [2:0] ST_WHOLE  = 3'd1;
	localparam logic [2:0] ST_CARVED = 3'd2;
	localparam logic [2:0] ST_NO_FIT = 3'd3;
	localparam logic [2:0] ST_NO_SLOT = 3'd4;
	localparam logic [2:0] ST_TICKED = 3'd5;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [4:0]        part_index;
		logic [KB_W-1:0]   part_size;
		logic [KB_W-1:0]   part_start;
		logic [KB_W-1:0]   req_size;
		logic [LIFE_W-1:0] job_lifetime;
	} req_item_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [4:0]      job_slot;
		logic [4:0]      partition;
		logic [KB_W-1:0] granted_size;
		logic [KB_W-1:0] granted_start;
		logic [5:0]      freed_count;
	} rsp_item_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;
		logic load_wr;
		logic alloc_step;
		logic alloc_fin;
		logic tick_step;
		logic tick_fin;
	} ffpa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;
	} ffpa_stat_t;

endpackage

// File: src/ffpa_ctrl.sv
// Command sequencer and response handshake for the allocator.
module ffpa_ctrl import ffpa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [1:0] req_cmd,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  ffpa_stat_t stat,
	output ffpa_cmd_t  cmds
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_ASCAN = 3'd2;
	localparam logic [2:0] S_AFIN  = 3'd3;
	localparam logic [2:0] S_TSCAN = 3'd4;
	localparam logic [2:0] S_TFIN  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       fin;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign fin       = cmds.load_wr || cmds.alloc_fin || cmds.tick_fin;

	always_comb begin
		state_d = state_q;
		cmds    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmds.latch = 1'b1;
					unique case (req_cmd)
						CMD_LOAD:  state_d = S_LOAD;
						CMD_ALLOC: state_d = S_ASCAN;
						CMD_TICK:  state_d = S_TSCAN;
						default:   state_d = S_IDLE; // unknown command: dropped
					endcase
				end
			end
			S_LOAD: begin
				if (out_free) begin
					cmds.load_wr = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_ASCAN: begin
				cmds.alloc_step = 1'b1;
				if (stat.last) state_d = S_AFIN;
			end
			S_AFIN: begin
				if (out_free) begin
					cmds.alloc_fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_TSCAN: begin
				cmds.tick_step = 1'b1;
				if (stat.last) state_d = S_TFIN;
			end
			S_TFIN: begin
				if (out_free) begin
					cmds.tick_fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmds))
		else $error("more than one datapath command at once");

	a_fin_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> (!rsp_valid || rsp_ready))
		else $error("response overwritten before it was taken");

	a_scan_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ASCAN && stat.last) |=> (state_q == S_AFIN))
		else $error("allocate scan did not end in its grant step");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !(cmds.alloc_step || cmds.tick_step))
		else $error("request accepted while a scan runs");

endmodule

// File: src/ffpa_dp.sv
// Partition and job-slot tables, scan counter and response register.
module ffpa_dp import ffpa_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  ffpa_cmd_t       cmds,
	output ffpa_stat_t      stat,
	input  req_item_t       req_item,
	input  logic            cfg_valid,
	input  logic [KB_W-1:0] cfg_data,
	output rsp_item_t       rsp_item
);

	logic [KB_W-1:0]   free_size_q  [NUM_PARTITIONS];
	logic [KB_W-1:0]   free_start_q [NUM_PARTITIONS];
	logic              free_avail_q [NUM_PARTITIONS];
	logic              slot_busy_q  [NUM_JOB_SLOTS];
	logic [LIFE_W-1:0] slot_ticks_q [NUM_JOB_SLOTS];
	logic [KB_W-1:0]   slot_size_q  [NUM_JOB_SLOTS];
	logic [PART_W-1:0] slot_part_q  [NUM_JOB_SLOTS];

	req_item_t         item_q;
	logic [KB_W-1:0]   limit_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              slot_found_q, part_found_q;
	logic [SLOT_W-1:0] slot_sel_q;
	logic [PART_W-1:0] part_sel_q;
	logic [FREED_W-1:0] freed_q;
	rsp_item_t         rsp_q, rsp_d;

	logic              cnt_in_part, cnt_in_slot;
	logic [PART_W-1:0] pi;
	logic [SLOT_W-1:0] sj;
	logic              fits;
	logic [PART_W-1:0] load_idx;
	logic              load_ok;
	// grant
	logic [KB_W-1:0]   g_size_pool, g_left, g_size, g_start;
	logic              g_whole;
	// reclaim
	logic [PART_W-1:0] rp;
	logic              expire;
	logic [KB_W:0]     r_sum;
	logic [KB_W-1:0]   r_size, r_start;

	assign cnt_in_part = (32'(cnt_q) < NUM_PARTITIONS);
	assign cnt_in_slot = (32'(cnt_q) < NUM_JOB_SLOTS);
	assign pi          = PART_W'(cnt_q);
	assign sj          = SLOT_W'(cnt_q);
	assign stat.last   = (32'(cnt_q) == SCAN_N - 1);
	assign rsp_item    = rsp_q;

	assign fits     = cnt_in_part && free_avail_q[pi] && (free_size_q[pi] >= item_q.req_size);
	assign load_idx = PART_W'(item_q.part_index);
	assign load_ok  = (32'(item_q.part_index) < NUM_PARTITIONS);

	assign g_size_pool = free_size_q[part_sel_q];
	assign g_start     = free_start_q[part_sel_q];
	assign g_left      = g_size_pool - item_q.req_size;
	assign g_whole     = (g_left <= limit_q);
	assign g_size      = g_whole ? g_size_pool : item_q.req_size;

	assign rp      = slot_part_q[sj];
	assign expire  = cnt_in_slot && slot_busy_q[sj] && (slot_ticks_q[sj] <= 4'd1);
	assign r_sum   = {1'b0, free_size_q[rp]} + {1'b0, slot_size_q[sj]};
	assign r_size  = r_sum[KB_W] ? KB_MAX : r_sum[KB_W-1:0];
	assign r_start = free_start_q[rp] - slot_size_q[sj];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LEFTOVER_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			slot_found_q <= 1'b0;
			part_found_q <= 1'b0;
			freed_q      <= '0;
		end else if (cmds.latch) begin
			cnt_q        <= '0;
			slot_found_q <= 1'b0;
			part_found_q <= 1'b0;
			freed_q      <= '0;
		end else begin
			if (cmds.alloc_step || cmds.tick_step) cnt_q <= cnt_q + 1'b1;
			if (cmds.alloc_step) begin
				if (!slot_found_q && cnt_in_slot && !slot_busy_q[sj]) slot_found_q <= 1'b1;
				if (!part_found_q && fits) part_found_q <= 1'b1;
			end
			if (cmds.tick_step && expire) freed_q <= freed_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmds.latch) item_q <= req_item;
		if (cmds.alloc_step) begin
			if (!slot_found_q) slot_sel_q <= sj;
			if (!part_found_q) part_sel_q <= pi;
		end
	end

	// partition table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PARTITIONS; i++) begin
				free_avail_q[i] <= 1'b0;
				free_size_q[i]  <= '0;
				free_start_q[i] <= '0;
			end
		end else begin
			priority if (cmds.load_wr) begin
				if (load_ok) begin
					free_size_q[load_idx]  <= item_q.part_size;
					free_start_q[load_idx] <= item_q.part_start;
					free_avail_q[load_idx] <= 1'b1;
				end
			end else if (cmds.alloc_fin) begin
				if (slot_found_q && part_found_q) begin
					free_start_q[part_sel_q] <= g_start + g_size;
					free_size_q[part_sel_q]  <= g_whole ? '0 : g_left;
					free_avail_q[part_sel_q] <= !g_whole;
				end
			end else if (cmds.tick_step) begin
				if (expire) begin
					free_size_q[rp]  <= r_size;
					free_start_q[rp] <= r_start;
					free_avail_q[rp] <= 1'b1;
				end
			end
		end
	end

	// job slot table: busy bits reset, the rest is written on grant and the tick count steps down on tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_JOB_SLOTS; j++) slot_busy_q[j] <= 1'b0;
		end else if (cmds.alloc_fin && slot_found_q && part_found_q) begin
			slot_busy_q[slot_sel_q] <= 1'b1;
		end else if (cmds.tick_step && expire) begin
			slot_busy_q[sj] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmds.alloc_fin && slot_found_q && part_found_q) begin
			slot_ticks_q[slot_sel_q] <= item_q.job_lifetime;
			slot_size_q[slot_sel_q]  <= g_size;
			slot_part_q[slot_sel_q]  <= part_sel_q;
		end else if (cmds.tick_step && cnt_in_slot && slot_busy_q[sj] && !expire) begin
			slot_ticks_q[sj] <= slot_ticks_q[sj] - 1'b1;
		end
	end

	// response register
	always_comb begin
		rsp_d = rsp_q;
		if (cmds.load_wr) begin
			rsp_d           = '0;
			rsp_d.status    = ST_LOADED;
			rsp_d.partition = item_q.part_index;
		end else if (cmds.alloc_fin) begin
			rsp_d = '0;
			priority if (!slot_found_q) begin
				rsp_d.status = ST_NO_SLOT;
			end else if (!part_found_q) begin
				rsp_d.status = ST_NO_FIT;
			end else begin
				rsp_d.status        = g_whole ? ST_WHOLE : ST_CARVED;
				rsp_d.job_slot      = 5'(slot_sel_q);
				rsp_d.partition     = 5'(part_sel_q);
				rsp_d.granted_size  = g_size;
				rsp_d.granted_start = g_start;
			end
		end else if (cmds.tick_fin) begin
			rsp_d             = '0;
			rsp_d.status      = ST_TICKED;
			rsp_d.freed_count = 6'(freed_q);
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

endmodule

// File: src/first_fit_partition_allocator.sv
// Top level of the first-fit partition allocator.
// One command per transaction, one response per load, allocate or tick command
// (command code 3 is dropped with no response). A single counter walks the
// partition and slot tables one entry per cycle: allocate looks for the first
// free slot and first fitting partition in the same pass, then grants in its
// final state; tick counts down one slot per cycle and returns expired jobs to
// their partitions as it goes. A finished response sits in an output register,
// so a new command is taken while the previous response waits. leftover_limit
// is written through cfg_data, always ready, and must only change while idle.
module first_fit_partition_allocator import ffpa_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  req_item_t       req_item,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output rsp_item_t       rsp_item,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [KB_W-1:0] cfg_data
);

	ffpa_cmd_t  cmds;
	ffpa_stat_t stat;

	assign cfg_ready = 1'b1;

	ffpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_cmd   (req_item.cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmds      (cmds)
	);

	ffpa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmds      (cmds),
		.stat      (stat),
		.req_item  (req_item),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.rsp_item  (rsp_item)
	);

endmodule

// File: bench/tb.sv
// Self-checking testbench for first_fit_partition_allocator.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ffpa_pkg::*;

	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = SCAN_N + 6;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_item_t req_item;
	logic rsp_valid;
	logic rsp_ready;
	rsp_item_t rsp_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [KB_W-1:0] cfg_data;

	first_fit_partition_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_item(req_item),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_item(rsp_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// shadow copy of the partition and job tables
	logic [KB_W-1:0]   part_size_kb [NUM_PARTITIONS];
	logic [KB_W-1:0]   part_start_kb [NUM_PARTITIONS];
	bit                part_open [NUM_PARTITIONS];
	bit                job_busy [NUM_JOB_SLOTS];
	logic [LIFE_W-1:0] job_ticks [NUM_JOB_SLOTS];
	logic [KB_W-1:0]   job_kb [NUM_JOB_SLOTS];
	logic [4:0]        job_part [NUM_JOB_SLOTS];
	logic [KB_W-1:0]   leftover_limit;

	rsp_item_t due_rsps[$];
	rsp_item_t want;
	int err_count;
	int quiet_cycles;
	int snd_idle_pct;
	int rcv_idle_pct;
	int hold_request;
	int hold_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_error(input string msg);
		err_count++;
		if (err_count <= 30)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] exp_val);
		if (got !== exp_val)
			report_error($sformatf("%s got %0d want %0d", name, got, exp_val));
	endtask

	// updates the shadow tables for one command; returns 1 when a response follows
	function automatic bit forecast_response(input req_item_t it, output rsp_item_t r);
		int slot;
		int part;
		int p;
		int sum;
		int freed;
		logic [KB_W-1:0] base;
		logic [KB_W-1:0] gsz;
		r = '0;
		case (it.cmd)
		CMD_LOAD: begin
			part_size_kb[it.part_index] = it.part_size;
			part_start_kb[it.part_index] = it.part_start;
			part_open[it.part_index] = 1'b1;
			r.status = ST_LOADED;
			r.partition = it.part_index;
			return 1'b1;
		end
		CMD_ALLOC: begin
			// reverse scans leave the lowest match
			slot = -1;
			for (int j = NUM_JOB_SLOTS - 1; j >= 0; j--)
				if (!job_busy[j])
					slot = j;
			if (slot < 0) begin
				r.status = ST_NO_SLOT;
				return 1'b1;
			end
			part = -1;
			for (int i = NUM_PARTITIONS - 1; i >= 0; i--)
				if (part_open[i] && part_size_kb[i] >= it.req_size)
					part = i;
			if (part < 0) begin
				r.status = ST_NO_FIT;
				return 1'b1;
			end
			base = part_start_kb[part];
			if (part_size_kb[part] - it.req_size <= leftover_limit) begin
				gsz = part_size_kb[part];
				part_size_kb[part] = '0;
				part_open[part] = 1'b0;
				r.status = ST_WHOLE;
			end else begin
				gsz = it.req_size;
				part_size_kb[part] = part_size_kb[part] - it.req_size;
				r.status = ST_CARVED;
			end
			part_start_kb[part] = base + gsz;
			job_busy[slot] = 1'b1;
			job_ticks[slot] = it.job_lifetime;
			job_kb[slot] = gsz;
			job_part[slot] = part[4:0];
			r.job_slot = slot[4:0];
			r.partition = part[4:0];
			r.granted_size = gsz;
			r.granted_start = base;
			return 1'b1;
		end
		CMD_TICK: begin
			freed = 0;
			for (int j = 0; j < NUM_JOB_SLOTS; j++) begin
				if (job_busy[j]) begin
					if (job_ticks[j] <= 1) begin
						p = int'(job_part[j]);
						job_busy[j] = 1'b0;
						job_ticks[j] = '0;
						freed++;
						sum = int'(part_size_kb[p]) + int'(job_kb[j]);
						part_size_kb[p] = (sum > KB_MAX) ? KB_MAX : sum[KB_W-1:0];
						part_start_kb[p] = part_start_kb[p] - job_kb[j];
						part_open[p] = 1'b1;
					end else begin
						job_ticks[j] = job_ticks[j] - 1'b1;
					end
				end
			end
			r.status = ST_TICKED;
			r.freed_count = freed[5:0];
			return 1'b1;
		end
		default: return 1'b0;
		endcase
	endfunction

	function automatic req_item_t scrambled_item();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		return bits[$bits(req_item_t)-1:0];
	endfunction

	function automatic req_item_t load_cmd(input int idx, input int size, input int start);
		req_item_t it;
		it = scrambled_item();
		it.cmd = CMD_LOAD;
		it.part_index = 5'(idx);
		it.part_size = KB_W'(size);
		it.part_start = KB_W'(start);
		return it;
	endfunction

	function automatic req_item_t alloc_cmd(input int size, input int life);
		req_item_t it;
		it = scrambled_item();
		it.cmd = CMD_ALLOC;
		it.req_size = KB_W'(size);
		it.job_lifetime = LIFE_W'(life);
		return it;
	endfunction

	function automatic req_item_t tick_cmd();
		req_item_t it;
		it = scrambled_item();
		it.cmd = CMD_TICK;
		return it;
	endfunction

	function automatic req_item_t random_command();
		req_item_t it;
		int pick;
		it = scrambled_item();
		pick = $urandom_range(99);
		if (pick < 20) begin
			it.cmd = CMD_LOAD;
		end else if (pick < 65) begin
			it.cmd = CMD_ALLOC;
			if ($urandom_range(99) < 65)
				it.req_size = KB_W'($urandom_range(63));
		end else if (pick < 95) begin
			it.cmd = CMD_TICK;
		end else begin
			it.cmd = CMD_UNKNOWN;
		end
		return it;
	endfunction

	task automatic offer_command(input req_item_t it);
		rsp_item_t r;
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_item <= it;
		do @(posedge clk); while (!req_ready);
		if (forecast_response(it, r))
			due_rsps.push_back(r);
	endtask

	// pause sending until the block has answered everything and gone quiet
	task automatic settle_idle();
		req_valid <= 1'b0;
		while (due_rsps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_leftover_limit(input logic [KB_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		leftover_limit = value;
	endtask

	task automatic test_directed_cases();
		offer_command(tick_cmd());
		offer_command(alloc_cmd(5, 3));          // nothing loaded yet
		offer_command(load_cmd(0, 1000, 1000));
		offer_command(load_cmd(31, 0, 1023));
		offer_command(load_cmd(5, 100, 0));
		offer_command(load_cmd(31, 0, 1023) ^ {2'b11, {($bits(req_item_t)-2){1'b0}}});
		offer_command(alloc_cmd(0, 0));          // zero request, zero lifetime
		offer_command(alloc_cmd(500, 1));        // carve wraps the start
		offer_command(alloc_cmd(490, 15));       // leftover equal to the limit
		offer_command(alloc_cmd(0, 2));
		offer_command(alloc_cmd(1023, 4));
		offer_command(load_cmd(0, 1000, 5));
		offer_command(tick_cmd());               // give-back saturates
		offer_command(alloc_cmd(1013, 5));
		offer_command(alloc_cmd(0, 6));
		offer_command(load_cmd(31, 1023, 1023));
		offer_command(tick_cmd());
		offer_command(alloc_cmd(1023, 7));       // whole grant, start wraps
		offer_command(tick_cmd());
		offer_command(load_cmd(17, 1023, 0));
		offer_command(alloc_cmd(1023, 0));
		settle_idle();
	endtask

	task automatic test_slot_exhaustion();
		for (int n = 0; n < 16; n++)
			offer_command(tick_cmd());
		offer_command(load_cmd(3, 1023, 0));
		for (int n = 0; n <= NUM_JOB_SLOTS; n++)
			offer_command(alloc_cmd(0, $urandom_range(15)));
		offer_command(alloc_cmd(1023, 9));       // no slot wins over no fit
		for (int n = 0; n < 16; n++)
			offer_command(tick_cmd());
		settle_idle();
	endtask

	task automatic test_random_traffic(input int count);
		for (int n = 0; n < count; n++)
			offer_command(random_command());
		settle_idle();
	endtask

	task automatic test_output_backpressure();
		hold_request = 200;
		for (int n = 0; n < 12; n++)
			offer_command(random_command());
		settle_idle();
	endtask

	// response side ready, with an optional long hold
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (due_rsps.size() == 0) begin
				report_error($sformatf("response with none pending, status %0d", rsp_item.status));
			end else begin
				want = due_rsps.pop_front();
				check_field("status", 16'(rsp_item.status), 16'(want.status));
				check_field("job_slot", 16'(rsp_item.job_slot), 16'(want.job_slot));
				check_field("partition", 16'(rsp_item.partition), 16'(want.partition));
				check_field("granted_size", 16'(rsp_item.granted_size),
					16'(want.granted_size));
				check_field("granted_start", 16'(rsp_item.granted_start),
					16'(want.granted_start));
				check_field("freed_count", 16'(rsp_item.freed_count),
					16'(want.freed_count));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("first_fit_partition_allocator test failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_item = '0;
		rsp_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		err_count = 0;
		quiet_cycles = 0;
		hold_request = 0;
		hold_left = 0;
		snd_idle_pct = 19;
		rcv_idle_pct = 62;
		leftover_limit = LEFTOVER_RESET;
		for (int i = 0; i < NUM_PARTITIONS; i++) begin
			part_size_kb[i] = '0;
			part_start_kb[i] = '0;
			part_open[i] = 1'b0;
		end
		for (int j = 0; j < NUM_JOB_SLOTS; j++) begin
			job_busy[j] = 1'b0;
			job_ticks[j] = '0;
			job_kb[j] = '0;
			job_part[j] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_slot_exhaustion();
		set_leftover_limit('0);
		test_random_traffic(120);

		snd_idle_pct = 62;
		rcv_idle_pct = 19;
		set_leftover_limit(KB_MAX);
		test_random_traffic(120);

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_output_backpressure();
		set_leftover_limit(KB_W'($urandom_range(1022, 1)));
		test_random_traffic(120);

		if (err_count == 0)
			$display("first_fit_partition_allocator test passed");
		else
			$display("first_fit_partition_allocator test failed");
		$finish;
	end

endmodule
